FILE: sv/abglm_pkg.sv
// ----------------------------------------------------------------------------
// abglm_pkg
// Shared types and constants for the audio block gain and level meter.
// ----------------------------------------------------------------------------
package abglm_pkg;

    // Sample format
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 10;
    localparam int PROD_W     = SAMPLE_W + GAIN_W;
    localparam int MAG_W      = PROD_W - GAIN_FRAC;

    // Square of a scaled magnitude (at most 2^30)
    localparam int SQ_ITEM_W  = 2 * SAMPLE_W - 1;

    // Gain clamp limits and reset value (unsigned Q6.10)
    localparam logic [GAIN_W-1:0] GAIN_MIN   = 16'd102;
    localparam logic [GAIN_W-1:0] GAIN_MAX   = 16'd32768;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd1024;

    // Saturation limits
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam int POS_LIMIT = 32767;
    localparam int NEG_LIMIT = 32768;

    // Square root unit: input word and number of digit steps
    localparam int SQRT_IN_W   = 2 * SAMPLE_W;
    localparam int SQRT_STEPS  = SQRT_IN_W / 2;
    localparam int SQRT_REM_W  = SAMPLE_W + 2;

    // Defaults for top-level parameters
    localparam int DEF_MAX_BLOCK_LEN = 4096;
    localparam int DEF_QUEUE_DEPTH   = 4;

    // Item passed from the front end to the back end through the queue
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] raw;
        logic                       last;
        logic signed [SAMPLE_W-1:0] scaled;
        logic [SQ_ITEM_W-1:0]       sq;
    } t_item;

    // One result transaction
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] scaled_sample;
        logic                       stats_valid;
        logic signed [SAMPLE_W-1:0] raw_min;
        logic signed [SAMPLE_W-1:0] raw_max;
        logic signed [SAMPLE_W-1:0] raw_mean;
        logic [SAMPLE_W-1:0]        peak;
        logic [SAMPLE_W-1:0]        rms;
    } t_result;

endpackage

FILE: sv/abglm_in_if.sv
// ----------------------------------------------------------------------------
// abglm_in_if
// Sample input channel: valid/ready handshake with a raw sample payload.
// ----------------------------------------------------------------------------
interface abglm_in_if;

    logic                                  valid;
    logic                                  ready;
    logic signed [abglm_pkg::SAMPLE_W-1:0] raw_sample;
    logic                                  last_of_block;

    modport source (output valid, output raw_sample, output last_of_block, input ready);
    modport sink   (input valid, input raw_sample, input last_of_block, output ready);

endinterface

FILE: sv/abglm_out_if.sv
// ----------------------------------------------------------------------------
// abglm_out_if
// Result channel: valid/ready handshake with scaled sample and block stats.
// ----------------------------------------------------------------------------
interface abglm_out_if;

    logic                                  valid;
    logic                                  ready;
    logic signed [abglm_pkg::SAMPLE_W-1:0] scaled_sample;
    logic                                  stats_valid;
    logic signed [abglm_pkg::SAMPLE_W-1:0] block_raw_min;
    logic signed [abglm_pkg::SAMPLE_W-1:0] block_raw_max;
    logic signed [abglm_pkg::SAMPLE_W-1:0] block_raw_mean;
    logic [abglm_pkg::SAMPLE_W-1:0]        block_peak;
    logic [abglm_pkg::SAMPLE_W-1:0]        block_rms;

    modport source (
        output valid, output scaled_sample, output stats_valid,
        output block_raw_min, output block_raw_max, output block_raw_mean,
        output block_peak, output block_rms, input ready
    );
    modport sink (
        input valid, input scaled_sample, input stats_valid,
        input block_raw_min, input block_raw_max, input block_raw_mean,
        input block_peak, input block_rms, output ready
    );

endinterface

FILE: sv/abglm_front.sv
// ----------------------------------------------------------------------------
// abglm_front
// Front end: gain register, two-stage gain multiply / saturate and square,
// feeding classified items into the queue.
// ----------------------------------------------------------------------------
module abglm_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [abglm_pkg::GAIN_W-1:0]     i_cfg_wdata,
    abglm_in_if.sink                         i_in,
    input  logic                             i_q_full,
    output logic                             o_q_push,
    output abglm_pkg::t_item                 o_q_item
);

    localparam int SW = abglm_pkg::SAMPLE_W;

    logic [abglm_pkg::GAIN_W-1:0]  r_gain;
    logic [abglm_pkg::GAIN_W-1:0]  n_gain;

    logic                          r_v1;
    logic signed [SW-1:0]          r_raw1;
    logic                          r_last1;

    logic                          r_v2;
    logic signed [SW-1:0]          r_raw2;
    logic                          r_last2;
    logic signed [SW-1:0]          r_scaled2;

    logic                          en1;
    logic                          en2;
    logic [SW-1:0]                 mag_in;
    logic [abglm_pkg::PROD_W-1:0]  prod;
    logic [abglm_pkg::MAG_W-1:0]   mag;
    logic signed [SW-1:0]          n_scaled;
    logic [SW-1:0]                 smag;

    // Clamp at write time; only the effective gain is ever used
    always_comb begin
        if (i_cfg_wdata < abglm_pkg::GAIN_MIN) begin
            n_gain = abglm_pkg::GAIN_MIN;
        end else if (i_cfg_wdata > abglm_pkg::GAIN_MAX) begin
            n_gain = abglm_pkg::GAIN_MAX;
        end else begin
            n_gain = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= abglm_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            r_gain <= n_gain;
        end
    end

    // Pipeline advance
    assign en2        = !r_v2 || !i_q_full;
    assign en1        = !r_v1 || en2;
    assign i_in.ready = en1;

    // Stage 1 -> 2: magnitude times gain, drop fraction, saturate
    always_comb begin
        mag_in = r_raw1[SW-1] ? SW'(-r_raw1) : SW'(r_raw1);
        prod   = abglm_pkg::PROD_W'(mag_in) * abglm_pkg::PROD_W'(r_gain);
        mag    = prod[abglm_pkg::PROD_W-1:abglm_pkg::GAIN_FRAC];
        if (r_raw1[SW-1]) begin
            if (mag > abglm_pkg::MAG_W'(abglm_pkg::NEG_LIMIT)) begin
                n_scaled = abglm_pkg::SAMPLE_MIN;
            end else begin
                n_scaled = SW'(0) - mag[SW-1:0];
            end
        end else begin
            if (mag > abglm_pkg::MAG_W'(abglm_pkg::POS_LIMIT)) begin
                n_scaled = abglm_pkg::SAMPLE_MAX;
            end else begin
                n_scaled = mag[SW-1:0];
            end
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in.valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_raw1  <= i_in.raw_sample;
            r_last1 <= i_in.last_of_block;
        end
        if (en2) begin
            r_raw2    <= r_raw1;
            r_last2   <= r_last1;
            r_scaled2 <= n_scaled;
        end
    end

    // Stage 2 -> queue: square of the scaled magnitude
    always_comb begin
        smag            = r_scaled2[SW-1] ? SW'(-r_scaled2) : SW'(r_scaled2);
        o_q_item.raw    = r_raw2;
        o_q_item.last   = r_last2;
        o_q_item.scaled = r_scaled2;
        o_q_item.sq     = abglm_pkg::SQ_ITEM_W'(abglm_pkg::PROD_W'(smag)
                                                * abglm_pkg::PROD_W'(smag));
    end

    assign o_q_push = r_v2 && !i_q_full;

endmodule

FILE: sv/abglm_fifo.sv
// ----------------------------------------------------------------------------
// abglm_fifo
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module abglm_fifo #(
    parameter int DEPTH = abglm_pkg::DEF_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  abglm_pkg::t_item  i_item,
    output logic              o_full,
    input  logic              i_pop,
    output abglm_pkg::t_item  o_item,
    output logic              o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    abglm_pkg::t_item  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt;

    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

FILE: sv/abglm_back.sv
// ----------------------------------------------------------------------------
// abglm_back
// Back end: block statistics, shared restoring divider and digit-by-digit
// square root for the end-of-block report, output register.
// ----------------------------------------------------------------------------
module abglm_back #(
    parameter int MAX_BLOCK_LEN = abglm_pkg::DEF_MAX_BLOCK_LEN
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  abglm_pkg::t_item  i_q_item,
    output logic              o_q_pop,
    abglm_out_if.source       o_out
);

    localparam int SW     = abglm_pkg::SAMPLE_W;
    localparam int CNT_W  = $clog2(MAX_BLOCK_LEN + 1);
    localparam int SUM_W  = SW + CNT_W;
    localparam int SQ_W   = abglm_pkg::SQ_ITEM_W - 1 + CNT_W;
    localparam int DW     = SQ_W;
    localparam int REM_W  = CNT_W + 1;
    localparam int STEP_W = $clog2(DW + 1);
    localparam int RT_W   = abglm_pkg::SQRT_REM_W;
    localparam int SV_W   = abglm_pkg::SQRT_IN_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCK_LEN);

    typedef enum logic [2:0] {
        S_RUN,
        S_MEAN,
        S_SQDIV,
        S_ROOT,
        S_DONE
    } t_state;

    t_state                r_state;

    // Running statistics
    logic [CNT_W-1:0]      r_cnt;
    logic signed [SW-1:0]  r_min;
    logic signed [SW-1:0]  r_max;
    logic signed [SUM_W-1:0] r_sum;
    logic [SW-1:0]         r_peak;
    logic [SQ_W-1:0]       r_sqsum;

    // Captured block results
    logic signed [SW-1:0]  r_fin_scaled;
    logic signed [SW-1:0]  r_fin_min;
    logic signed [SW-1:0]  r_fin_max;
    logic [SW-1:0]         r_fin_peak;
    logic [SQ_W-1:0]       r_fin_sq;
    logic [CNT_W-1:0]      r_fin_cnt;
    logic                  r_fin_neg;
    logic signed [SW-1:0]  r_fin_mean;

    // Divider and square root working registers
    logic [DW-1:0]         r_quo;
    logic [REM_W-1:0]      r_rem;
    logic [STEP_W-1:0]     r_step;
    logic [SV_W-1:0]       r_sqv;
    logic [RT_W-1:0]       r_srem;
    logic [SW-1:0]         r_root;

    // Output register
    logic                  r_out_valid;
    abglm_pkg::t_result    r_out;

    logic                  out_free;
    logic                  take;
    logic                  load_out;
    logic                  count_ok;
    logic [SW-1:0]         smag;
    logic [CNT_W-1:0]      n_cnt;
    logic signed [SW-1:0]  n_min;
    logic signed [SW-1:0]  n_max;
    logic signed [SUM_W-1:0] n_sum;
    logic [SW-1:0]         n_peak;
    logic [SQ_W-1:0]       n_sqsum;
    logic [SUM_W-1:0]      sum_mag;
    logic [REM_W-1:0]      rem_sh;
    logic                  q_bit;
    logic [REM_W-1:0]      n_rem;
    logic [DW-1:0]         n_quo;
    logic [RT_W-1:0]       s_rem;
    logic [RT_W-1:0]       s_trial;
    logic                  r_bit;
    logic [RT_W-1:0]       n_srem;
    logic [SW-1:0]         n_root;

    assign out_free = !r_out_valid || o_out.ready;
    assign take     = (r_state == S_RUN) && i_q_valid && out_free;
    assign o_q_pop  = take;
    assign load_out = (take && !i_q_item.last) || ((r_state == S_DONE) && out_free);

    // Statistics update for the item at the queue head
    always_comb begin
        smag     = i_q_item.scaled[SW-1] ? SW'(-i_q_item.scaled) : SW'(i_q_item.scaled);
        count_ok = (r_cnt < MAX_CNT);
        n_cnt    = r_cnt;
        n_min    = r_min;
        n_max    = r_max;
        n_sum    = r_sum;
        n_peak   = r_peak;
        n_sqsum  = r_sqsum;
        if (count_ok) begin
            n_cnt   = r_cnt + CNT_W'(1);
            n_min   = (i_q_item.raw < r_min) ? i_q_item.raw : r_min;
            n_max   = (i_q_item.raw > r_max) ? i_q_item.raw : r_max;
            n_sum   = r_sum + SUM_W'(i_q_item.raw);
            n_peak  = (smag > r_peak) ? smag : r_peak;
            n_sqsum = r_sqsum + SQ_W'(i_q_item.sq);
        end
        sum_mag = n_sum[SUM_W-1] ? SUM_W'(-n_sum) : SUM_W'(n_sum);
    end

    // One restoring division step
    always_comb begin
        rem_sh = {r_rem[CNT_W-1:0], r_quo[DW-1]};
        q_bit  = (rem_sh >= {1'b0, r_fin_cnt});
        n_rem  = q_bit ? rem_sh - {1'b0, r_fin_cnt} : rem_sh;
        n_quo  = {r_quo[DW-2:0], q_bit};
    end

    // One square root digit step
    always_comb begin
        s_rem   = {r_srem[RT_W-3:0], r_sqv[SV_W-1 -: 2]};
        s_trial = {r_root, 2'b01};
        r_bit   = (s_rem >= s_trial);
        n_srem  = r_bit ? s_rem - s_trial : s_rem;
        n_root  = {r_root[SW-2:0], r_bit};
    end

    // Sequencer, statistics and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_min       <= abglm_pkg::SAMPLE_MAX;
            r_max       <= abglm_pkg::SAMPLE_MIN;
            r_sum       <= '0;
            r_peak      <= '0;
            r_sqsum     <= '0;
        end else begin
            // Output valid: set when a result is loaded, cleared once taken
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_RUN: begin
                    if (take) begin
                        if (i_q_item.last) begin
                            // Capture the block and restart statistics
                            r_fin_scaled <= i_q_item.scaled;
                            r_fin_min    <= n_min;
                            r_fin_max    <= n_max;
                            r_fin_peak   <= n_peak;
                            r_fin_sq     <= n_sqsum;
                            r_fin_cnt    <= n_cnt;
                            r_fin_neg    <= n_sum[SUM_W-1];
                            r_quo        <= DW'(sum_mag);
                            r_rem        <= '0;
                            r_step       <= STEP_W'(DW);
                            r_cnt        <= '0;
                            r_min        <= abglm_pkg::SAMPLE_MAX;
                            r_max        <= abglm_pkg::SAMPLE_MIN;
                            r_sum        <= '0;
                            r_peak       <= '0;
                            r_sqsum      <= '0;
                            r_state      <= S_MEAN;
                        end else begin
                            r_cnt         <= n_cnt;
                            r_min         <= n_min;
                            r_max         <= n_max;
                            r_sum         <= n_sum;
                            r_peak        <= n_peak;
                            r_sqsum       <= n_sqsum;
                            r_out         <= '{scaled_sample: i_q_item.scaled, default: '0};
                        end
                    end
                end
                S_MEAN: begin
                    if (r_step == STEP_W'(1)) begin
                        r_fin_mean <= r_fin_neg ? SW'(0) - n_quo[SW-1:0] : n_quo[SW-1:0];
                        r_quo      <= r_fin_sq;
                        r_rem      <= '0;
                        r_step     <= STEP_W'(DW);
                        r_state    <= S_SQDIV;
                    end else begin
                        r_quo  <= n_quo;
                        r_rem  <= n_rem;
                        r_step <= r_step - STEP_W'(1);
                    end
                end
                S_SQDIV: begin
                    if (r_step == STEP_W'(1)) begin
                        r_sqv   <= SV_W'(n_quo[abglm_pkg::SQ_ITEM_W-1:0]);
                        r_srem  <= '0;
                        r_root  <= '0;
                        r_step  <= STEP_W'(abglm_pkg::SQRT_STEPS);
                        r_state <= S_ROOT;
                    end else begin
                        r_quo  <= n_quo;
                        r_rem  <= n_rem;
                        r_step <= r_step - STEP_W'(1);
                    end
                end
                S_ROOT: begin
                    r_sqv  <= {r_sqv[SV_W-3:0], 2'b00};
                    r_srem <= n_srem;
                    r_root <= n_root;
                    r_step <= r_step - STEP_W'(1);
                    if (r_step == STEP_W'(1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out.scaled_sample <= r_fin_scaled;
                        r_out.stats_valid   <= 1'b1;
                        r_out.raw_min       <= r_fin_min;
                        r_out.raw_max       <= r_fin_max;
                        r_out.raw_mean      <= r_fin_mean;
                        r_out.peak          <= r_fin_peak;
                        r_out.rms           <= r_root;
                        r_state             <= S_RUN;
                    end
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase
        end
    end

    // Result channel
    assign o_out.valid          = r_out_valid;
    assign o_out.scaled_sample  = r_out.scaled_sample;
    assign o_out.stats_valid    = r_out.stats_valid;
    assign o_out.block_raw_min  = r_out.raw_min;
    assign o_out.block_raw_max  = r_out.raw_max;
    assign o_out.block_raw_mean = r_out.raw_mean;
    assign o_out.block_peak     = r_out.peak;
    assign o_out.block_rms      = r_out.rms;

endmodule

FILE: sv/audio_block_gain_level_meter_top.sv
// ----------------------------------------------------------------------------
// audio_block_gain_level_meter_top
// Gain stage with block min / max / mean and peak / RMS level meter.
//
//   Channel   Dir   Handshake        Payload
//   i_in      in    valid / ready    raw_sample, last_of_block
//   o_out     out   valid / ready    scaled_sample, stats_valid, block_* fields
//   i_cfg_*   in    write enable     gain_q10 (unsigned Q6.10, clamped to 0.1 .. 32.0)
//
// The back end takes a sample that does not end a block straight into the output
// register; samples stream at one per cycle while the queue has items and the
// output register is free. A last-of-block sample holds the back end for two
// passes of the shared radix-2 divider, one step per dividend bit, then 16 square
// root steps and the report state. The front end keeps filling the queue
// meanwhile.
// Reset is synchronous; no clearing pass. Either side may stall at any time.
// ----------------------------------------------------------------------------
module audio_block_gain_level_meter_top #(
    parameter int MAX_BLOCK_LEN = abglm_pkg::DEF_MAX_BLOCK_LEN,
    parameter int QUEUE_DEPTH   = abglm_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [abglm_pkg::GAIN_W-1:0]  i_cfg_wdata,
    abglm_in_if.sink                      i_in,
    abglm_out_if.source                   o_out
);

    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_empty;
    abglm_pkg::t_item  q_wr_item;
    abglm_pkg::t_item  q_rd_item;

    // Gain and square pipeline
    abglm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_item    (q_wr_item)
    );

    // Decoupling queue
    abglm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_wr_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_rd_item),
        .o_empty (q_empty)
    );

    // Statistics and report
    abglm_back #(
        .MAX_BLOCK_LEN (MAX_BLOCK_LEN)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (!q_empty),
        .i_q_item  (q_rd_item),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

`ifndef NO_ASSERTIONS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    a_push_nonfull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue pushed while full");

    a_mean_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.stats_valid) |->
            (o_out.block_raw_min <= o_out.block_raw_mean) &&
            (o_out.block_raw_mean <= o_out.block_raw_max))
        else $error("block mean outside min / max");

    a_rms_le_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.stats_valid) |-> (o_out.block_rms <= o_out.block_peak))
        else $error("block rms above peak");

    a_stats_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.stats_valid) |->
            (o_out.block_raw_min == '0) && (o_out.block_raw_max == '0) &&
            (o_out.block_raw_mean == '0) && (o_out.block_peak == '0) &&
            (o_out.block_rms == '0))
        else $error("stat fields nonzero outside block end");
`endif

endmodule
